### rtl/core/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// next-cycle property, switched off while reset is held
`define LMCR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle property that also covers the reset cycles
`define LMCR_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/lmcr_pkg.sv
package lmcr_pkg;

    // number of drivers on the chain (1 to 4)
    localparam int CHAIN_LENGTH = 4;
    localparam int ROWS_PER_DEVICE = 8;
    localparam int WIDTH_PIXELS = CHAIN_LENGTH * ROWS_PER_DEVICE;
    localparam int DEPTH = CHAIN_LENGTH * ROWS_PER_DEVICE;
    localparam int DEV_W = (CHAIN_LENGTH > 1) ? $clog2(CHAIN_LENGTH) : 1;
    localparam int IDX_W = $clog2(DEPTH);
    // word slots in one chain frame
    localparam int SLOTS = 4;
    localparam int FRAME_W = SLOTS * 16;

    // driver register codes
    localparam logic [7:0] NOOP_REG = 8'h00;
    localparam logic [7:0] ROW0_REG = 8'h01;
    localparam logic [15:0] NOOP_WORD = {NOOP_REG, 8'h00};

    // command kinds on the input stream
    localparam logic [2:0] KIND_COLUMN  = 3'd0;
    localparam logic [2:0] KIND_PIXEL   = 3'd1;
    localparam logic [2:0] KIND_CLEAR   = 3'd2;
    localparam logic [2:0] KIND_REFRESH = 3'd3;
    localparam logic [2:0] KIND_BCAST   = 3'd4;

    typedef enum logic [2:0] {
        OP_COLUMN,
        OP_PIXEL,
        OP_CLEAR,
        OP_REFRESH,
        OP_BCAST
    } op_t;

    // one classified command as held in the queue
    typedef struct packed {
        op_t              op;
        logic [DEV_W-1:0] dev;
        logic [2:0]       row;
        logic [7:0]       mask;
        logic [3:0]       height;
        logic             pixel_on;
        logic [15:0]      word;
    } cmd_t;

    // queue status seen by the front and back ends
    typedef struct packed {
        logic full;
        logic valid;
    } q_status_t;

endpackage

### rtl/core/lmcr_front.sv
module lmcr_front (
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,
    input  logic [2:0]          s_tuser,
    input  lmcr_pkg::q_status_t q_status,
    output logic                push,
    output lmcr_pkg::cmd_t      push_cmd
);

    logic [5:0] column;
    logic [3:0] row;
    logic [7:0] height;
    logic       keep;

    assign column = s_tdata[5:0];
    assign row    = s_tdata[9:6];
    assign height = s_tdata[17:10];

    // accept whenever the queue has room
    assign s_tready = !q_status.full;
    assign push     = s_tvalid && s_tready && keep;

    // classify and drop commands that do nothing
    always_comb begin
        keep              = 1'b0;
        push_cmd.op       = lmcr_pkg::OP_BCAST;
        push_cmd.dev      = column[3 +: lmcr_pkg::DEV_W];
        push_cmd.row      = row[2:0];
        push_cmd.mask     = 8'h80 >> column[2:0];
        push_cmd.height   = (height > 8'd8) ? 4'd8 : height[3:0];
        push_cmd.pixel_on = s_tdata[18];
        push_cmd.word     = {4'b0000, s_tdata[22:19], s_tdata[30:23]};
        unique case (s_tuser)
            lmcr_pkg::KIND_COLUMN: begin
                push_cmd.op = lmcr_pkg::OP_COLUMN;
                keep = ({1'b0, column} < 7'(lmcr_pkg::WIDTH_PIXELS));
            end
            lmcr_pkg::KIND_PIXEL: begin
                push_cmd.op = lmcr_pkg::OP_PIXEL;
                keep = ({1'b0, column} < 7'(lmcr_pkg::WIDTH_PIXELS)) && !row[3];
            end
            lmcr_pkg::KIND_CLEAR: begin
                push_cmd.op = lmcr_pkg::OP_CLEAR;
                keep = 1'b1;
            end
            lmcr_pkg::KIND_REFRESH: begin
                push_cmd.op = lmcr_pkg::OP_REFRESH;
                keep = 1'b1;
            end
            lmcr_pkg::KIND_BCAST: begin
                push_cmd.op = lmcr_pkg::OP_BCAST;
                keep = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

endmodule

### rtl/core/lmcr_cmd_queue.sv
module lmcr_cmd_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  lmcr_pkg::cmd_t      push_cmd,
    input  logic                pop,
    output lmcr_pkg::q_status_t q_status,
    output lmcr_pkg::cmd_t      head_cmd
);

    lmcr_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;

    assign q_status.full  = (count_reg == 2'd2);
    assign q_status.valid = (count_reg != 2'd0);
    assign head_cmd       = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### rtl/core/lmcr_back.sv
module lmcr_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  lmcr_pkg::q_status_t q_status,
    input  lmcr_pkg::cmd_t      head_cmd,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [63:0]         m_tdata,
    output logic                m_tlast
);

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t                         state_reg, state_next;
    lmcr_pkg::op_t                  op_reg, op_next;
    logic [2:0]                     row_reg, row_next;
    logic [lmcr_pkg::DEV_W-1:0]     dev_reg, dev_next;
    logic [15:0]                    word_reg, word_next;
    logic [7:0]                     pix_reg [lmcr_pkg::DEPTH];
    logic [7:0]                     pix_next [lmcr_pkg::DEPTH];
    logic                           valid_reg, valid_next;
    logic [lmcr_pkg::FRAME_W-1:0]   frame_reg, frame_next;
    logic                           last_reg, last_next;

    logic                           out_free;
    logic [lmcr_pkg::IDX_W-1:0]     rd_idx;
    logic [lmcr_pkg::IDX_W-1:0]     wr_idx;
    logic [15:0]                    cur_word;
    logic                           cur_last;
    logic [lmcr_pkg::FRAME_W-1:0]   cur_frame;
    logic [3:0]                     lit_sum;

    assign m_tvalid = valid_reg;
    assign m_tdata  = frame_reg;
    assign m_tlast  = last_reg;

    assign out_free = !valid_reg || m_tready;
    assign pop      = (state_reg == ST_IDLE) && q_status.valid;
    assign rd_idx   = lmcr_pkg::IDX_W'({dev_reg, row_reg});
    assign wr_idx   = lmcr_pkg::IDX_W'({head_cmd.dev, head_cmd.row});

    // word and last flag of the frame in progress
    always_comb begin
        cur_word = word_reg;
        cur_last = 1'b1;
        unique case (op_reg)
            lmcr_pkg::OP_CLEAR: begin
                cur_word = {lmcr_pkg::ROW0_REG + {5'b00000, row_reg}, 8'h00};
                cur_last = (row_reg == 3'd7);
            end
            lmcr_pkg::OP_REFRESH: begin
                cur_word = {lmcr_pkg::ROW0_REG + {5'b00000, row_reg}, pix_reg[rd_idx]};
                cur_last = (row_reg == 3'd7)
                        && (dev_reg == lmcr_pkg::DEV_W'(lmcr_pkg::CHAIN_LENGTH - 1));
            end
            default: begin
                cur_word = word_reg;
                cur_last = 1'b1;
            end
        endcase
    end

    // place words in slots, farthest device in the top slot
    always_comb begin
        cur_frame = '0;
        for (int s = 0; s < lmcr_pkg::SLOTS; s++) begin
            if (s < lmcr_pkg::CHAIN_LENGTH) begin
                if (op_reg != lmcr_pkg::OP_REFRESH
                    || dev_reg == lmcr_pkg::DEV_W'(lmcr_pkg::CHAIN_LENGTH - 1 - s)) begin
                    cur_frame[(lmcr_pkg::SLOTS - 1 - s) * 16 +: 16] = cur_word;
                end else begin
                    cur_frame[(lmcr_pkg::SLOTS - 1 - s) * 16 +: 16] = lmcr_pkg::NOOP_WORD;
                end
            end
        end
    end

    // command sequencer and framebuffer update
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        row_next   = row_reg;
        dev_next   = dev_reg;
        word_next  = word_reg;
        pix_next   = pix_reg;
        valid_next = valid_reg && !m_tready;
        frame_next = frame_reg;
        last_next  = last_reg;
        lit_sum    = 4'd0;
        unique case (state_reg)
            ST_IDLE: begin
                if (pop) begin
                    op_next   = head_cmd.op;
                    row_next  = 3'd0;
                    dev_next  = '0;
                    word_next = head_cmd.word;
                    unique case (head_cmd.op)
                        lmcr_pkg::OP_COLUMN: begin
                            // bottom rows lit, rows above darkened
                            for (int d = 0; d < lmcr_pkg::CHAIN_LENGTH; d++) begin
                                for (int y = 0; y < lmcr_pkg::ROWS_PER_DEVICE; y++) begin
                                    if (head_cmd.dev == lmcr_pkg::DEV_W'(d)) begin
                                        lit_sum = 4'(y) + head_cmd.height;
                                        if (lit_sum[3]) begin
                                            pix_next[d * 8 + y] =
                                                pix_reg[d * 8 + y] | head_cmd.mask;
                                        end else begin
                                            pix_next[d * 8 + y] =
                                                pix_reg[d * 8 + y] & ~head_cmd.mask;
                                        end
                                    end
                                end
                            end
                        end
                        lmcr_pkg::OP_PIXEL: begin
                            if (head_cmd.pixel_on) begin
                                pix_next[wr_idx] = pix_reg[wr_idx] | head_cmd.mask;
                            end else begin
                                pix_next[wr_idx] = pix_reg[wr_idx] & ~head_cmd.mask;
                            end
                        end
                        lmcr_pkg::OP_CLEAR: begin
                            for (int e = 0; e < lmcr_pkg::DEPTH; e++) begin
                                pix_next[e] = 8'h00;
                            end
                            state_next = ST_EMIT;
                        end
                        default: begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    valid_next = 1'b1;
                    frame_next = cur_frame;
                    last_next  = cur_last;
                    if (cur_last) begin
                        state_next = ST_IDLE;
                    end else if (op_reg == lmcr_pkg::OP_REFRESH
                                 && dev_reg != lmcr_pkg::DEV_W'(lmcr_pkg::CHAIN_LENGTH - 1)) begin
                        dev_next = dev_reg + lmcr_pkg::DEV_W'(1);
                    end else begin
                        dev_next = '0;
                        row_next = row_reg + 3'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            for (int e = 0; e < lmcr_pkg::DEPTH; e++) begin
                pix_reg[e] <= 8'h00;
            end
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            pix_reg   <= pix_next;
        end
        op_reg    <= op_next;
        row_reg   <= row_next;
        dev_reg   <= dev_next;
        word_reg  <= word_next;
        frame_reg <= frame_next;
        last_reg  <= last_next;
    end

endmodule

### rtl/core/led_matrix_chain_refresh.sv
// a command's frames pass the queue entry, the sequencer state and the output register
// output: one frame per cycle within a command while m_tready is high; the back-end
//   sequencer applies pixel and column writes in its idle state and emits frames in
//   its emit state (a refresh is 8*CHAIN_LENGTH frames)
// reset: synchronous, active low; clears the framebuffer, the command queue and the output
//   valid, after which s_tready is high
module led_matrix_chain_refresh (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // column[5:0], row[9:6], height[17:10], pixel_on[18],
                                   // reg_address[22:19], reg_data[30:23], zero[31]
    input  logic [2:0]  s_tuser,   // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // chain_frame[63:0]
    output logic        m_tlast    // last
);

    lmcr_pkg::q_status_t q_status;
    lmcr_pkg::cmd_t      push_cmd;
    lmcr_pkg::cmd_t      head_cmd;
    logic                push;
    logic                pop;

    // accept and classify commands
    lmcr_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // two-entry queue between the halves
    lmcr_cmd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .q_status (q_status),
        .head_cmd (head_cmd)
    );

    // framebuffer and frame sequencer
    lmcr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .head_cmd (head_cmd),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

### rtl/core/lmcr_checker.sv
`include "assert_macros.svh"

module lmcr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tlast
);

    logic        clean;
    logic        stall;
    logic        mid_run;
    logic [64:0] out_bus;

    assign clean   = s_tready && !m_tvalid;
    assign stall   = m_tvalid && !m_tready;
    assign mid_run = m_tvalid && m_tready && !m_tlast;
    assign out_bus = {m_tlast, m_tdata};

    // after a reset cycle the queue is empty and no frame is pending
    `LMCR_ASSERT_NEXT_ALWAYS(a_reset_clean, aclk, !aresetn, clean, "not clean after reset")

    // a stalled frame holds
    `LMCR_ASSERT_NEXT(a_hold, aclk, aresetn, stall, m_tvalid && $stable(out_bus), "frame changed")

    // frames of one command follow without a gap
    `LMCR_ASSERT_NEXT(a_no_gap, aclk, aresetn, mid_run, m_tvalid, "gap inside a command's frames")

endmodule

bind led_matrix_chain_refresh lmcr_checker u_lmcr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### dv/tb_led_matrix_chain_refresh.sv
`timescale 1ns / 100ps

module tb_led_matrix_chain_refresh;

    import lmcr_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_CMDS = 330;
    // no idling once the backlog has drained below this
    localparam int QUIET_TAIL  = 40;
    localparam int DRAIN_WAIT  = 24;

    // one host command as placed on the input stream
    typedef struct {
        logic [2:0] kind;
        logic [5:0] column;
        logic [3:0] row;
        logic [7:0] height;
        logic       pixel_on;
        logic [3:0] reg_address;
        logic [7:0] reg_data;
    } host_cmd_t;

    typedef struct {
        logic [63:0] frame;
        logic        last;
    } chain_frame_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tlast;

    host_cmd_t    cmd_backlog[$];
    chain_frame_t frame_expect[$];
    logic [7:0]   pixel_rows[DEPTH];

    int  mismatches = 0;
    int  stall_cycles = 0;
    int  send_gap = 0;
    int  ready_gap = 0;
    bit  in_fired = 1'b0;

    led_matrix_chain_refresh dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #6 aclk = ~aclk;

    // frame that writes one device and sends no-op words to the others
    function automatic logic [63:0] frame_to_one(input int target, input logic [15:0] w);
        logic [63:0] f;
        int slot;
        f = '0;
        for (slot = 0; slot < CHAIN_LENGTH; slot++)
            f[FRAME_W - 16 - 16 * slot +: 16] = (CHAIN_LENGTH - 1 - slot == target) ? w : NOOP_WORD;
        return f;
    endfunction

    function automatic logic [63:0] frame_to_all(input logic [15:0] w);
        logic [63:0] f;
        int slot;
        f = '0;
        for (slot = 0; slot < CHAIN_LENGTH; slot++)
            f[FRAME_W - 16 - 16 * slot +: 16] = w;
        return f;
    endfunction

    function automatic void push_frame(input logic [63:0] f, input logic l);
        chain_frame_t e;
        e.frame = f;
        e.last = l;
        frame_expect.push_back(e);
    endfunction

    // framebuffer update and the chain frames a command produces
    function automatic void predict_frames(input host_cmd_t c);
        int dev, y, lit;
        logic [7:0] mask;
        logic [7:0] reg_code;
        mask = 8'h80 >> c.column[2:0];
        dev = c.column / ROWS_PER_DEVICE;
        case (c.kind)
            KIND_COLUMN: begin
                if (c.column < WIDTH_PIXELS) begin
                    lit = (c.height > ROWS_PER_DEVICE) ? ROWS_PER_DEVICE : c.height;
                    for (y = 0; y < ROWS_PER_DEVICE; y++) begin
                        if (y >= ROWS_PER_DEVICE - lit)
                            pixel_rows[dev * ROWS_PER_DEVICE + y] |= mask;
                        else
                            pixel_rows[dev * ROWS_PER_DEVICE + y] &= ~mask;
                    end
                end
            end
            KIND_PIXEL: begin
                if (c.column < WIDTH_PIXELS && c.row < ROWS_PER_DEVICE) begin
                    if (c.pixel_on)
                        pixel_rows[dev * ROWS_PER_DEVICE + c.row] |= mask;
                    else
                        pixel_rows[dev * ROWS_PER_DEVICE + c.row] &= ~mask;
                end
            end
            KIND_CLEAR: begin
                for (y = 0; y < DEPTH; y++)
                    pixel_rows[y] = '0;
                for (y = 0; y < ROWS_PER_DEVICE; y++) begin
                    reg_code = 8'(ROW0_REG + y);
                    push_frame(frame_to_all({reg_code, 8'h00}), y == ROWS_PER_DEVICE - 1);
                end
            end
            KIND_REFRESH: begin
                for (y = 0; y < ROWS_PER_DEVICE; y++) begin
                    reg_code = 8'(ROW0_REG + y);
                    for (dev = 0; dev < CHAIN_LENGTH; dev++)
                        push_frame(frame_to_one(dev,
                                       {reg_code, pixel_rows[dev * ROWS_PER_DEVICE + y]}),
                                   y == ROWS_PER_DEVICE - 1 && dev == CHAIN_LENGTH - 1);
                end
            end
            KIND_BCAST: begin
                push_frame(frame_to_all({4'h0, c.reg_address, c.reg_data}), 1'b1);
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] frame check: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic queue_cmd(input logic [2:0] kind, input logic [5:0] column,
                             input logic [3:0] row, input logic [7:0] height,
                             input logic pixel_on, input logic [3:0] reg_address,
                             input logic [7:0] reg_data);
        host_cmd_t c;
        c.kind = kind;
        c.column = column;
        c.row = row;
        c.height = height;
        c.pixel_on = pixel_on;
        c.reg_address = reg_address;
        c.reg_data = reg_data;
        cmd_backlog.push_back(c);
    endtask

    // mostly framebuffer writes in range, with refreshes, clears, broadcasts and some noise
    function automatic host_cmd_t random_cmd();
        host_cmd_t c;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            c.kind = KIND_COLUMN;
        else if (pick < 63)
            c.kind = KIND_PIXEL;
        else if (pick < 73)
            c.kind = KIND_REFRESH;
        else if (pick < 78)
            c.kind = KIND_CLEAR;
        else if (pick < 92)
            c.kind = KIND_BCAST;
        else
            c.kind = 3'($urandom_range(KIND_BCAST + 1, 7));
        if ($urandom_range(0, 5) == 0)
            c.column = 6'($urandom_range(WIDTH_PIXELS, 63));
        else
            c.column = 6'($urandom_range(0, WIDTH_PIXELS - 1));
        if ($urandom_range(0, 5) == 0)
            c.row = 4'($urandom_range(ROWS_PER_DEVICE, 15));
        else
            c.row = 4'($urandom_range(0, ROWS_PER_DEVICE - 1));
        if ($urandom_range(0, 1) == 0)
            c.height = 8'($urandom_range(0, ROWS_PER_DEVICE + 1));
        else
            c.height = 8'($urandom_range(0, 255));
        c.pixel_on = 1'($urandom_range(0, 1));
        c.reg_address = 4'($urandom_range(0, 15));
        c.reg_data = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // input driver: holds each transfer until taken, with random gaps
    always @(negedge aclk) begin
        logic        next_valid;
        logic [31:0] next_data;
        logic [2:0]  next_user;
        host_cmd_t   c;
        next_valid = s_tvalid;
        next_data = s_tdata;
        next_user = s_tuser;
        if (aresetn && (!s_tvalid || in_fired)) begin
            next_valid = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (cmd_backlog.size() != 0) begin
                if (cmd_backlog.size() >= QUIET_TAIL && $urandom_range(0, 3) == 0) begin
                    send_gap = $urandom_range(0, 7);
                end else begin
                    c = cmd_backlog.pop_front();
                    next_valid = 1'b1;
                    next_data = {1'b0, c.reg_data, c.reg_address, c.pixel_on,
                                 c.height, c.row, c.column};
                    next_user = c.kind;
                end
            end
        end
        s_tvalid <= next_valid;
        s_tdata <= next_data;
        s_tuser <= next_user;
    end

    // result side back-pressure in bursts
    always @(negedge aclk) begin
        logic next_ready;
        next_ready = 1'b1;
        if (!aresetn) begin
            next_ready = 1'b0;
        end else if (ready_gap > 0) begin
            ready_gap--;
            next_ready = 1'b0;
        end else if (cmd_backlog.size() >= QUIET_TAIL && $urandom_range(0, 4) == 0) begin
            ready_gap = $urandom_range(0, 7);
            next_ready = 1'b0;
        end
        m_tready <= next_ready;
    end

    // monitor: predict on input transfers, check on output transfers
    always @(posedge aclk) begin
        host_cmd_t    c;
        chain_frame_t e;
        in_fired = aresetn && s_tvalid && s_tready;
        if (in_fired) begin
            c.kind = s_tuser;
            c.column = s_tdata[5:0];
            c.row = s_tdata[9:6];
            c.height = s_tdata[17:10];
            c.pixel_on = s_tdata[18];
            c.reg_address = s_tdata[22:19];
            c.reg_data = s_tdata[30:23];
            predict_frames(c);
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (frame_expect.size() == 0) begin
                report_mismatch($sformatf("unexpected frame %h last %b", m_tdata, m_tlast));
            end else begin
                e = frame_expect.pop_front();
                if (m_tdata !== e.frame)
                    report_mismatch($sformatf("chain_frame %h, wanted %h", m_tdata, e.frame));
                if (m_tlast !== e.last)
                    report_mismatch($sformatf("last %b, wanted %b on frame %h",
                                              m_tlast, e.last, e.frame));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("led_matrix_chain_refresh: mismatch");
            $finish;
        end
    end

    initial begin
        int i, y;
        for (y = 0; y < DEPTH; y++)
            pixel_rows[y] = '0;

        // directed: broadcast extremes, blank refresh, bars and pixels at the edges
        queue_cmd(KIND_BCAST,   6'd0,  4'd0,  8'd0,   1'b0, 4'h0, 8'h00);
        queue_cmd(KIND_BCAST,   6'd63, 4'd15, 8'd255, 1'b1, 4'hf, 8'hff);
        queue_cmd(KIND_REFRESH, 6'd0,  4'd0,  8'd0,   1'b0, 4'h0, 8'h00);
        queue_cmd(KIND_COLUMN,  6'd0,  4'd0,  8'd8,   1'b0, 4'h0, 8'h00);
        queue_cmd(KIND_COLUMN,  6'd31, 4'd0,  8'd255, 1'b0, 4'h0, 8'h00);
        queue_cmd(KIND_COLUMN,  6'd9,  4'd0,  8'd9,   1'b0, 4'h0, 8'h00);
        queue_cmd(KIND_COLUMN,  6'd17, 4'd0,  8'd3,   1'b0, 4'h0, 8'h00);
        queue_cmd(KIND_COLUMN,  6'd24, 4'd0,  8'd0,   1'b0, 4'h0, 8'h00);
        // column out of range leaves the buffer alone
        queue_cmd(KIND_COLUMN,  6'd32, 4'd0,  8'd8,   1'b0, 4'h0, 8'h00);
        queue_cmd(KIND_COLUMN,  6'd63, 4'd0,  8'd8,   1'b0, 4'h0, 8'h00);
        queue_cmd(KIND_PIXEL,   6'd0,  4'd0,  8'd0,   1'b1, 4'h0, 8'h00);
        queue_cmd(KIND_PIXEL,   6'd31, 4'd7,  8'd0,   1'b1, 4'h0, 8'h00);
        queue_cmd(KIND_PIXEL,   6'd0,  4'd7,  8'd0,   1'b0, 4'h0, 8'h00);
        queue_cmd(KIND_PIXEL,   6'd12, 4'd4,  8'd0,   1'b1, 4'h0, 8'h00);
        // pixel with row or column out of range is dropped
        queue_cmd(KIND_PIXEL,   6'd7,  4'd8,  8'd0,   1'b1, 4'h0, 8'h00);
        queue_cmd(KIND_PIXEL,   6'd5,  4'd15, 8'd0,   1'b1, 4'h0, 8'h00);
        queue_cmd(KIND_PIXEL,   6'd40, 4'd3,  8'd0,   1'b1, 4'h0, 8'h00);
        queue_cmd(KIND_REFRESH, 6'd0,  4'd0,  8'd0,   1'b0, 4'h0, 8'h00);
        // unknown kinds produce nothing
        queue_cmd(3'd5,         6'd1,  4'd1,  8'd1,   1'b1, 4'h1, 8'h01);
        queue_cmd(3'd6,         6'd2,  4'd2,  8'd2,   1'b1, 4'h2, 8'h02);
        queue_cmd(3'd7,         6'd3,  4'd3,  8'd3,   1'b1, 4'h3, 8'h03);
        queue_cmd(KIND_CLEAR,   6'd0,  4'd0,  8'd0,   1'b0, 4'h0, 8'h00);
        queue_cmd(KIND_REFRESH, 6'd0,  4'd0,  8'd0,   1'b0, 4'h0, 8'h00);

        for (i = 0; i < RANDOM_CMDS; i++)
            cmd_backlog.push_back(random_cmd());
        queue_cmd(KIND_REFRESH, 6'd0, 4'd0, 8'd0, 1'b0, 4'h0, 8'h00);

        // reset
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // drain inputs, then outstanding frames, then a quiet tail
        while (cmd_backlog.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (frame_expect.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (mismatches == 0)
            $display("led_matrix_chain_refresh: match");
        else
            $display("led_matrix_chain_refresh: mismatch");
        $finish;
    end

endmodule
